/* design/hfd_pkg.sv */
// Shared constants for the Hermite fractional delay block.
package hfd_pkg;

  // Fraction bits of delays, read positions and the interpolation phase.
  localparam int FRAC_BITS = 16;

  // Width of the signed Q12.16 delay offset field.
  localparam int OFFSET_WIDTH = 28;

  // Fixed base delay in whole samples, added to every offset.
  localparam int BASE_DELAY = 64;

  // Smallest clamped delay in whole samples; the largest is DEPTH minus this.
  localparam int DELAY_MARGIN = 4;

  // Smoothing coefficient register.
  localparam int COEFF_WIDTH = 16;
  localparam logic [COEFF_WIDTH-1:0] COEFF_RESET = 16'd120;

endpackage

/* design/hfd_in_if.sv */
// Input channel: one audio sample and its delay offset per word.
interface hfd_in_if #(
  parameter int SAMPLE_WIDTH = 24
);
  logic                                      valid;
  logic                                      ready;
  logic signed [SAMPLE_WIDTH-1:0]            sample_in;
  logic signed [hfd_pkg::OFFSET_WIDTH-1:0]   delay_offset;

  modport source (output valid, output sample_in, output delay_offset, input ready);
  modport sink (input valid, input sample_in, input delay_offset, output ready);
endinterface

/* design/hfd_out_if.sv */
// Output channel: one interpolated delayed sample per word.
interface hfd_out_if #(
  parameter int SAMPLE_WIDTH = 24
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink (input valid, input sample_out, output ready);
endinterface

/* design/hfd_tap_store.sv */
// Circular sample store with write pointer, fill tracking and one registered read port.
module hfd_tap_store #(
  parameter int DEPTH        = 2048,
  parameter int SAMPLE_WIDTH = 24
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             wr_en,
  input  logic signed [SAMPLE_WIDTH-1:0]   wr_data,
  input  logic                             adv,
  input  logic                             rd_en,
  input  logic [$clog2(DEPTH)-1:0]         rd_addr,
  output logic [$clog2(DEPTH)-1:0]         wptr,
  output logic signed [SAMPLE_WIDTH-1:0]   rd_data
);

  localparam int AW = $clog2(DEPTH);

  logic [SAMPLE_WIDTH-1:0] mem [DEPTH];
  logic [SAMPLE_WIDTH-1:0] mem_q;
  logic [AW-1:0]           wp;
  logic                    wrapped;
  logic                    hit;

  // Write pointer; entries are filled in order from zero, so once the pointer
  // has wrapped every entry holds a written sample.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp      <= '0;
      wrapped <= 1'b0;
    end else if (adv) begin
      wp <= wp + AW'(1);
      if (wp == AW'(DEPTH - 1)) begin
        wrapped <= 1'b1;
      end
    end
  end

  // An entry at or below the pointer has been written since reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else if (rd_en) begin
      hit <= wrapped || (rd_addr <= wp);
    end
  end

  // Sample memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wp] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  // Entries never written read as zero, as after a cleared reset.
  assign rd_data = hit ? $signed(mem_q) : '0;
  assign wptr    = wp;

endmodule

/* design/hermite_fractional_delay.sv */
// Top level of the modulated fractional delay line with cubic Hermite interpolation.
//
//   Channel   Direction  Word contents
//   din       in         sample_in (signed Q1.23), delay_offset (signed Q12.16)
//   dout      out        sample_out (signed Q1.23, saturated)
//   cfg       in         cfg_we / cfg_data: smoothing coefficient, Q0.16
//
// A new word is accepted only in the idle state: din.ready stays low after an acceptance
// while the sequencer runs, until it returns to idle.
// The sequencer's length is set by the one shared multiplier (smoothing step and three
// Horner steps) and the single read port of the sample memory (four taps).
// Reset is synchronous; unwritten memory entries read as zero via fill tracking.
// A finished word sits in the output register; the next input word is taken
// meanwhile, and the sequencer only waits at its last step if dout is still full.
module hermite_fractional_delay #(
  parameter int DEPTH        = 2048,
  parameter int SAMPLE_WIDTH = 24
) (
  input  logic                               clk,
  input  logic                               rst,
  hfd_in_if.sink                             din,
  hfd_out_if.source                          dout,
  input  logic                               cfg_we,
  input  logic [hfd_pkg::COEFF_WIDTH-1:0]    cfg_data
);

  localparam int FB = hfd_pkg::FRAC_BITS;
  localparam int AW = $clog2(DEPTH);
  localparam int DW = AW + FB;                        // smoothed delay width
  localparam int TW = (DW + 2 > 30) ? DW + 2 : 30;    // target arithmetic width
  localparam int SW = SAMPLE_WIDTH;
  localparam int CW = SW + 4;                         // polynomial coefficients
  localparam int HW = SW + 6;                         // Horner accumulator
  localparam int MA = (DW + 1 > HW) ? DW + 1 : HW;    // multiplier operand A
  localparam int PW = MA + FB + 1;                    // product width

  localparam logic signed [TW-1:0] BASE   = TW'(hfd_pkg::BASE_DELAY) <<< FB;
  localparam logic signed [TW-1:0] LO_LIM = TW'(hfd_pkg::DELAY_MARGIN) <<< FB;
  localparam logic signed [TW-1:0] HI_LIM = TW'(DEPTH - hfd_pkg::DELAY_MARGIN) <<< FB;
  localparam logic signed [PW-1:0] HALF   = PW'(1) <<< (FB - 1);

  // Sequencer states.
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DIFF = 4'd1;
  localparam logic [3:0] S_SMUL = 4'd2;
  localparam logic [3:0] S_SUPD = 4'd3;
  localparam logic [3:0] S_POS  = 4'd4;
  localparam logic [3:0] S_READ = 4'd5;
  localparam logic [3:0] S_COEF = 4'd6;
  localparam logic [3:0] S_HMUL = 4'd7;
  localparam logic [3:0] S_HSHR = 4'd8;
  localparam logic [3:0] S_FIN  = 4'd9;

  logic [3:0]                     state;
  logic [2:0]                     rk;
  logic [1:0]                     hs;
  logic                           ov;
  logic [hfd_pkg::COEFF_WIDTH-1:0] coeff;
  logic [DW-1:0]                  smoothed;

  logic [DW-1:0]                  target;
  logic signed [DW:0]             diff;
  logic [AW-1:0]                  idx;
  logic [FB-1:0]                  frac;
  logic signed [SW-1:0]           tap [4];
  logic signed [CW-1:0]           c0, c1, c2, c3;
  logic signed [HW-1:0]           h;
  logic signed [PW-1:0]           prod;
  logic signed [SW-1:0]           y_reg;

  logic                           accept;
  logic                           out_free;
  logic                           load_out;
  logic signed [TW-1:0]           sum;
  logic signed [TW-1:0]           clamped;
  logic signed [PW-1:0]           rounded;
  logic [DW-1:0]                  pos;
  logic                           rd_en;
  logic [AW-1:0]                  rd_addr;
  logic [AW-1:0]                  wptr;
  logic signed [SW-1:0]           rd_data;
  logic [1:0]                     cap_idx;
  logic signed [CW-1:0]           ta, tb, tc, td;
  logic signed [CW-1:0]           csel;
  logic signed [HW-1:0]           hsum;
  logic signed [MA-1:0]           op_a;
  logic signed [FB:0]             op_b;
  logic signed [HW:0]             ysum;
  logic signed [HW:0]             yhalf;
  logic signed [SW-1:0]           ysat;

  assign accept   = din.valid && din.ready;
  assign out_free = !ov || dout.ready;
  assign load_out = (state == S_FIN) && out_free;

  assign din.ready       = (state == S_IDLE);
  assign dout.valid      = ov;
  assign dout.sample_out = y_reg;

  // Requested delay: offset plus base, clamped to the usable span.
  always_comb begin
    sum     = TW'(din.delay_offset) + BASE;
    clamped = sum;
    if (sum < LO_LIM) begin
      clamped = LO_LIM;
    end
    if (sum > HI_LIM) begin
      clamped = HI_LIM;
    end
  end

  // Smoothing increment, rounded half up, and the read position.
  assign rounded = (prod + HALF) >>> FB;
  assign pos     = {wptr, FB'(0)} - smoothed;

  // Tap reads cover index-1 .. index+2, wrapping around the memory.
  assign rd_en   = (state == S_READ) && (rk < 3'd4);
  assign rd_addr = idx + AW'(rk) - AW'(1);
  assign cap_idx = 2'(rk - 3'd1);

  // Polynomial coefficients from the four taps.
  always_comb begin
    ta = CW'(tap[0]);
    tb = CW'(tap[1]);
    tc = CW'(tap[2]);
    td = CW'(tap[3]);
  end

  // Shared multiplier operands: smoothing step or one Horner step.
  always_comb begin
    case (hs)
      2'd0:    csel = c3;
      2'd1:    csel = c2;
      default: csel = c1;
    endcase
    hsum = h + HW'(csel);
    if (state == S_SMUL) begin
      op_a = MA'(diff);
      op_b = $signed({1'b0, coeff});
    end else begin
      op_a = MA'(hsum);
      op_b = $signed({1'b0, frac});
    end
  end

  // Final halving with round-up, then saturation to the sample width.
  always_comb begin
    ysum  = (HW + 1)'(h) + (HW + 1)'(c0) + (HW + 1)'(1);
    yhalf = ysum >>> 1;
    if (yhalf[HW:SW-1] == {(HW - SW + 2){yhalf[HW]}}) begin
      ysat = yhalf[SW-1:0];
    end else if (yhalf[HW]) begin
      ysat = {1'b1, {(SW - 1){1'b0}}};
    end else begin
      ysat = {1'b0, {(SW - 1){1'b1}}};
    end
  end

  // Sequencer, configuration register and smoothed delay.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      rk       <= '0;
      hs       <= '0;
      ov       <= 1'b0;
      coeff    <= hfd_pkg::COEFF_RESET;
      smoothed <= '0;
    end else begin
      if (cfg_we) begin
        coeff <= cfg_data;
      end
      // The output register fills from the final step and empties when taken.
      if (load_out) begin
        ov <= 1'b1;
      end else if (dout.ready) begin
        ov <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_DIFF;
          end
        end
        S_DIFF: state <= S_SMUL;
        S_SMUL: state <= S_SUPD;
        S_SUPD: begin
          smoothed <= smoothed + DW'(rounded);
          state    <= S_POS;
        end
        S_POS: begin
          rk    <= '0;
          state <= S_READ;
        end
        S_READ: begin
          if (rk == 3'd4) begin
            state <= S_COEF;
          end else begin
            rk <= rk + 3'd1;
          end
        end
        S_COEF: begin
          hs    <= '0;
          state <= S_HMUL;
        end
        S_HMUL: state <= S_HSHR;
        S_HSHR: begin
          if (hs == 2'd2) begin
            state <= S_FIN;
          end else begin
            hs    <= hs + 2'd1;
            state <= S_HMUL;
          end
        end
        S_FIN: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      target <= DW'(clamped);
    end
    if (state == S_DIFF) begin
      diff <= $signed({1'b0, target}) - $signed({1'b0, smoothed});
    end
    if (state == S_SMUL || state == S_HMUL) begin
      prod <= op_a * op_b;
    end
    if (state == S_POS) begin
      idx  <= pos[DW-1:FB];
      frac <= pos[FB-1:0];
    end
    if (state == S_READ && rk != 3'd0) begin
      tap[cap_idx] <= rd_data;
    end
    if (state == S_COEF) begin
      c0 <= tb <<< 1;
      c1 <= tc - ta;
      c2 <= (ta <<< 1) - ((tb <<< 2) + tb) + (tc <<< 2) - td;
      c3 <= tb + (tb <<< 1) - ta - (tc + (tc <<< 1)) + td;
      h  <= '0;
    end
    if (state == S_HSHR) begin
      h <= HW'(prod >>> FB);
    end
    if (load_out) begin
      y_reg <= ysat;
    end
  end

  // Sample memory with the write pointer.
  hfd_tap_store #(
    .DEPTH        (DEPTH),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (accept),
    .wr_data (din.sample_in),
    .adv     (load_out),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .wptr    (wptr),
    .rd_data (rd_data)
  );

  // The block takes no new word in the cycle after one is accepted.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    accept |=> !din.ready)
    else $error("input accepted while a word is in progress");

  // The smoother never moves past the upper clamp bound.
  a_smoothed_bound: assert property (@(posedge clk) disable iff (rst)
    smoothed <= DW'(HI_LIM))
    else $error("smoothed delay beyond the clamp bound");

  // A result appears only from the final sequencer step.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(ov) |-> $past(state) == S_FIN)
    else $error("output word raised outside the final step");

  // The write pointer moves once per word, when its result is loaded.
  a_pointer_step: assert property (@(posedge clk) disable iff (rst)
    (wptr != $past(wptr)) |-> $past(load_out))
    else $error("write pointer moved without a finished word");

endmodule
